/* rtl/mqtt_rx_pkg.sv */
package mqtt_rx_pkg;

  typedef enum logic [2:0] {
    PH_HDR   = 3'd0,
    PH_LEN   = 3'd1,
    PH_TLEN  = 3'd2,
    PH_TOPIC = 3'd3,
    PH_PAY   = 3'd4,
    PH_OTHER = 3'd5,
    PH_DROP  = 3'd6
  } phase_t;

  localparam logic [2:0] ROLE_HEADER  = 3'd0;
  localparam logic [2:0] ROLE_LENGTH  = 3'd1;
  localparam logic [2:0] ROLE_TLEN    = 3'd2;
  localparam logic [2:0] ROLE_TOPIC   = 3'd3;
  localparam logic [2:0] ROLE_PAYLOAD = 3'd4;
  localparam logic [2:0] ROLE_OTHER   = 3'd5;
  localparam logic [2:0] ROLE_DROPPED = 3'd6;

  localparam logic [2:0] EV_NONE        = 3'd0;
  localparam logic [2:0] EV_CONN_OK     = 3'd1;
  localparam logic [2:0] EV_CONN_REFUSE = 3'd2;
  localparam logic [2:0] EV_BAD_LENGTH  = 3'd3;
  localparam logic [2:0] EV_BAD_PUBLISH = 3'd4;

  localparam logic [3:0] TYPE_CONNACK = 4'h2;
  localparam logic [3:0] TYPE_PUBLISH = 4'h3;

  localparam int unsigned LEN_W   = 28;
  localparam int unsigned TOPIC_W = 16;

endpackage

/* rtl/mqtt_receive_deframer_unit.sv */
// MQTT 3.1.1 receive deframer: one received byte in, one tagged byte out, at up to one
// byte per clock while the output is not stalled. Each byte is captured in an input
// register, parsed combinationally against the packet state and presented in an output
// register; a stalled output holds the byte in the input register, and the parse state
// is updated as the byte moves to the output register. Every result carries the byte's
// role, the current packet type, end of packet, the connected flag, CONNACK and error
// events, the PUBLISH topic length once known and the decoded remaining length.
module mqtt_receive_deframer_unit
  import mqtt_rx_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_data_byte,
  output logic [2:0]           out_byte_role,
  output logic [3:0]           out_packet_type,
  output logic                 out_end_of_packet,
  output logic                 out_link_up,
  output logic [2:0]           out_event_res,
  output logic [7:0]           out_refusal_code,
  output logic [TOPIC_W-1:0]   out_topic_size,
  output logic [LEN_W-1:0]     out_body_size
);

  logic               in_valid_r;
  logic [7:0]         in_byte_r;
  logic               out_valid_r;
  logic               advance;

  phase_t             phase_r, phase_nxt;
  logic [3:0]         type_r, type_nxt;
  logic [LEN_W-1:0]   accum_r, accum_nxt;
  logic [1:0]         lbc_r, lbc_nxt;
  logic [LEN_W-1:0]   body_left_r, body_left_nxt;
  logic [1:0]         body_pos_r, body_pos_nxt;
  logic [TOPIC_W-1:0] topic_len_r, topic_len_nxt;
  logic [TOPIC_W-1:0] topic_left_r, topic_left_nxt;
  logic               conn_r, conn_nxt;

  logic [LEN_W-1:0]   len_part;
  logic [LEN_W-1:0]   body_dec;
  logic               body_byte;
  logic [2:0]         role;
  logic [2:0]         ev;
  logic [7:0]         code;
  logic               eop;
  logic [7:0]         b;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign b         = in_byte_r;
  assign body_dec  = body_left_r - LEN_W'(1);

  always_comb begin
    case (lbc_r)
      2'd0:    len_part = {21'b0, b[6:0]};
      2'd1:    len_part = {14'b0, b[6:0], 7'b0};
      2'd2:    len_part = {7'b0, b[6:0], 14'b0};
      default: len_part = {b[6:0], 21'b0};
    endcase
  end

  always_comb begin
    phase_nxt      = phase_r;
    type_nxt       = type_r;
    accum_nxt      = accum_r;
    lbc_nxt        = lbc_r;
    body_left_nxt  = body_left_r;
    body_pos_nxt   = body_pos_r;
    topic_len_nxt  = topic_len_r;
    topic_left_nxt = topic_left_r;
    conn_nxt       = conn_r;
    role           = ROLE_HEADER;
    ev             = EV_NONE;
    code           = 8'd0;
    eop            = 1'b0;
    body_byte      = 1'b0;
    case (phase_r)
      PH_LEN: begin
        role      = ROLE_LENGTH;
        accum_nxt = accum_r | len_part;
        if (b[7]) begin
          if (lbc_r == 2'd3) begin
            ev        = EV_BAD_LENGTH;
            phase_nxt = PH_HDR;
          end else begin
            lbc_nxt = lbc_r + 2'd1;
          end
        end else begin
          body_left_nxt = accum_nxt;
          body_pos_nxt  = 2'd0;
          if (accum_nxt == '0) begin
            eop       = 1'b1;
            phase_nxt = PH_HDR;
            if (type_r == TYPE_CONNACK) begin
              ev = EV_CONN_REFUSE;
            end else if (type_r == TYPE_PUBLISH) begin
              ev = EV_BAD_PUBLISH;
            end
          end else if (type_r == TYPE_PUBLISH) begin
            if (accum_nxt < LEN_W'(2)) begin
              ev        = EV_BAD_PUBLISH;
              phase_nxt = PH_DROP;
            end else begin
              phase_nxt = PH_TLEN;
            end
          end else begin
            phase_nxt = PH_OTHER;
          end
        end
      end
      PH_TLEN: begin
        role          = ROLE_TLEN;
        body_byte     = 1'b1;
        body_left_nxt = body_dec;
        if (body_pos_r == 2'd0) begin
          topic_len_nxt = {b, 8'h00};
          body_pos_nxt  = 2'd1;
        end else begin
          topic_len_nxt = topic_len_r | {8'h00, b};
          body_pos_nxt  = 2'd2;
          if ({12'b0, topic_len_nxt} > body_dec) begin
            ev        = EV_BAD_PUBLISH;
            phase_nxt = PH_DROP;
          end else begin
            topic_left_nxt = topic_len_nxt;
            phase_nxt      = (topic_len_nxt != '0) ? PH_TOPIC : PH_PAY;
          end
        end
      end
      PH_TOPIC: begin
        role           = ROLE_TOPIC;
        body_byte      = 1'b1;
        body_left_nxt  = body_dec;
        topic_left_nxt = topic_left_r - TOPIC_W'(1);
        if (topic_left_nxt == '0) begin
          phase_nxt = PH_PAY;
        end
      end
      PH_PAY: begin
        role          = ROLE_PAYLOAD;
        body_byte     = 1'b1;
        body_left_nxt = body_dec;
      end
      PH_DROP: begin
        role          = ROLE_DROPPED;
        body_byte     = 1'b1;
        body_left_nxt = body_dec;
      end
      PH_OTHER: begin
        role      = ROLE_OTHER;
        body_byte = 1'b1;
        if (type_r == TYPE_CONNACK) begin
          if (body_pos_r == 2'd1) begin
            if (b == 8'd0) begin
              conn_nxt = 1'b1;
              ev       = EV_CONN_OK;
            end else begin
              ev   = EV_CONN_REFUSE;
              code = b;
            end
          end else if (body_pos_r == 2'd0 && body_left_r == LEN_W'(1)) begin
            ev = EV_CONN_REFUSE;
          end
        end
        if (body_pos_r < 2'd2) begin
          body_pos_nxt = body_pos_r + 2'd1;
        end
        body_left_nxt = body_dec;
      end
      default: begin
        role           = ROLE_HEADER;
        type_nxt       = b[7:4];
        accum_nxt      = '0;
        lbc_nxt        = 2'd0;
        body_left_nxt  = '0;
        body_pos_nxt   = 2'd0;
        topic_len_nxt  = '0;
        topic_left_nxt = '0;
        phase_nxt      = PH_LEN;
      end
    endcase
    if (body_byte && body_left_nxt == '0) begin
      eop       = 1'b1;
      phase_nxt = PH_HDR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      phase_r      <= PH_HDR;
      type_r       <= 4'd0;
      accum_r      <= '0;
      lbc_r        <= 2'd0;
      body_left_r  <= '0;
      body_pos_r   <= 2'd0;
      topic_len_r  <= '0;
      topic_left_r <= '0;
      conn_r       <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r  <= 1'b1;
        phase_r      <= phase_nxt;
        type_r       <= type_nxt;
        accum_r      <= accum_nxt;
        lbc_r        <= lbc_nxt;
        body_left_r  <= body_left_nxt;
        body_pos_r   <= body_pos_nxt;
        topic_len_r  <= topic_len_nxt;
        topic_left_r <= topic_left_nxt;
        conn_r       <= conn_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
    if (advance) begin
      out_data_byte     <= b;
      out_byte_role     <= role;
      out_packet_type   <= type_nxt;
      out_end_of_packet <= eop;
      out_link_up       <= conn_nxt;
      out_event_res     <= ev;
      out_refusal_code  <= code;
      out_topic_size    <= (type_nxt == TYPE_PUBLISH && body_pos_nxt == 2'd2) ?
                           topic_len_nxt : '0;
      out_body_size     <= accum_nxt;
    end
  end

endmodule
